/* rtl/disparity_to_point_xyz_assert.svh */
// ----------------------------------------------------------------------------
// disparity_to_point_xyz assertion macros
// Shorthand for clocked implications checked outside of reset.
// ----------------------------------------------------------------------------
`ifndef DISPARITY_TO_POINT_XYZ_ASSERT_SVH
`define DISPARITY_TO_POINT_XYZ_ASSERT_SVH

// same-cycle implication
`define DXYZ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define DXYZ_ASSERT_AFTER(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

/* rtl/dxyz_pkg.sv */
// ----------------------------------------------------------------------------
// dxyz_pkg
// Shared types and constants of the disparity to point converter.
// ----------------------------------------------------------------------------
package dxyz_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned Q_W       = 32;
    localparam int unsigned DIV_LAT   = Q_W + 1;
    localparam int unsigned LATENCY   = DIV_LAT + 4;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SHIFT = 3'd0,
        REG_BASE  = 3'd1,
        REG_FX    = 3'd2,
        REG_FY    = 3'd3,
        REG_CX    = 3'd4,
        REG_CY    = 3'd5
    } t_reg_idx;

    localparam logic [CFG_W-1:0] RST_SHIFT = 16'd17440;
    localparam logic [CFG_W-1:0] RST_BASE  = 16'd4915;
    localparam logic [CFG_W-1:0] RST_FX    = 16'd9280;
    localparam logic [CFG_W-1:0] RST_FY    = 16'd9280;
    localparam logic [CFG_W-1:0] RST_CX    = 16'd5120;
    localparam logic [CFG_W-1:0] RST_CY    = 16'd3840;

    typedef struct packed {
        logic vld;
        logic pv;
        logic neg_x;
        logic neg_y;
        logic fy_nz;
    } t_meta;

endpackage

/* rtl/disparity_to_point_xyz.sv */
// ----------------------------------------------------------------------------
// disparity_to_point_xyz
// Converts a pixel (column, row, raw disparity) into a 3-D point in mm Q.4.
//
// Input: a word is taken at each clock edge with start high and busy low.
// busy is always low, so a new pixel may enter every cycle.
// Output: each result word is shown for one cycle with o_strobe high;
// one result per cycle sustained. Three front stages form numerators
// and denominators, then three parallel 33-stage divider chains (an
// input stage, then one quotient bit per cell) finish the work, then
// one saturation stage registers the result.
// The receiver cannot stall; results are never held.
// Config: write channel i_cfg_valid / o_cfg_ready (always high) with
// register index and data; write only while no pixel is in flight.
// Reset: synchronous, active low; registers return to calibration
// defaults and all in-flight words are dropped.
// ----------------------------------------------------------------------------
`include "disparity_to_point_xyz_assert.svh"

module disparity_to_point_xyz (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [11:0]                        i_column,
    input  logic [11:0]                        i_row,
    input  logic [10:0]                        i_raw_disparity,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dxyz_pkg::REG_IDX_W-1:0]     i_cfg_index,
    input  logic [dxyz_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                               o_strobe,
    output logic [31:0]                        o_point_x,
    output logic [31:0]                        o_point_y,
    output logic [30:0]                        o_point_z,
    output logic                               o_point_valid
);

    localparam int unsigned QW = dxyz_pkg::Q_W;
    localparam int unsigned ML = dxyz_pkg::DIV_LAT;

    logic [15:0] r_shift, r_base, r_fx, r_fy, r_cx, r_cy;

    logic signed [17:0] w_d, w_ex, w_ey;
    logic [17:0]        w_ax, w_ay;
    dxyz_pkg::t_meta    n_m1;

    dxyz_pkg::t_meta r_m1, r_m2, r_m3;
    dxyz_pkg::t_meta r_ml [ML];
    logic [15:0] r1_d, r1_ax, r1_ay;
    logic [31:0] r1_bf;
    logic [15:0] r2_d, r2_ay;
    logic [38:0] r2_nz;
    logic [31:0] r2_px, r2_dfy;
    logic [38:0] r3_nz, r3_nx;
    logic [54:0] r3_ny;
    logic [21:0] r3_dz;
    logic [37:0] r3_dy;

    logic [QW-1:0] w_qx, w_qy, w_qz;
    logic          w_ox, w_oy, w_oz;

    logic        r_strobe, r_pv;
    logic [31:0] r_x, r_y;
    logic [30:0] r_z;

    function automatic logic [31:0] sat_signed(input logic [31:0] q, input logic ovf,
                                               input logic neg);
        logic [31:0] m;
        if (neg) begin
            m = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : q;
            return ~m + 32'd1;
        end
        return (ovf || q[31]) ? 32'h7FFF_FFFF : q;
    endfunction

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= dxyz_pkg::RST_SHIFT;
            r_base  <= dxyz_pkg::RST_BASE;
            r_fx    <= dxyz_pkg::RST_FX;
            r_fy    <= dxyz_pkg::RST_FY;
            r_cx    <= dxyz_pkg::RST_CX;
            r_cy    <= dxyz_pkg::RST_CY;
        end else if (i_cfg_valid) begin
            unique case (dxyz_pkg::t_reg_idx'(i_cfg_index))
                dxyz_pkg::REG_SHIFT: r_shift <= i_cfg_data;
                dxyz_pkg::REG_BASE:  r_base  <= i_cfg_data;
                dxyz_pkg::REG_FX:    r_fx    <= i_cfg_data;
                dxyz_pkg::REG_FY:    r_fy    <= i_cfg_data;
                dxyz_pkg::REG_CX:    r_cx    <= i_cfg_data;
                dxyz_pkg::REG_CY:    r_cy    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_d  = $signed({2'b0, r_shift}) - $signed({3'b0, i_raw_disparity, 4'b0});
        w_ex = $signed({2'b0, i_column, 4'b0}) - $signed({2'b0, r_cx});
        w_ey = $signed({2'b0, i_row, 4'b0}) - $signed({2'b0, r_cy});
        w_ax = w_ex[17] ? 18'(-w_ex) : 18'(w_ex);
        w_ay = w_ey[17] ? 18'(-w_ey) : 18'(w_ey);
        n_m1.vld   = start && !busy;
        n_m1.pv    = (w_d > 18'sd0) && (r_base != '0) && (r_fx != '0);
        n_m1.neg_x = w_ex[17];
        n_m1.neg_y = w_ey[17];
        n_m1.fy_nz = (r_fy != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1 <= '0;
            r_m2 <= '0;
            r_m3 <= '0;
            for (int i = 0; i < ML; i++) begin
                r_ml[i] <= '0;
            end
        end else begin
            r_m1    <= n_m1;
            r_m2    <= r_m1;
            r_m3    <= r_m2;
            r_ml[0] <= r_m3;
            for (int i = 1; i < ML; i++) begin
                r_ml[i] <= r_ml[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_d   <= w_d[15:0];
        r1_ax  <= w_ax[15:0];
        r1_ay  <= w_ay[15:0];
        r1_bf  <= 32'(r_base) * 32'(r_fx);

        r2_d   <= r1_d;
        r2_ay  <= r1_ay;
        r2_nz  <= {r1_bf, 7'b0} - 39'({r1_bf, 2'b0}) + 39'(r1_bf);
        r2_px  <= 32'(r_base) * 32'(r1_ax);
        r2_dfy <= 32'(r1_d) * 32'(r_fy);

        r3_nz  <= r2_nz;
        r3_ny  <= 55'(r2_nz) * 55'(r2_ay);
        r3_nx  <= {r2_px, 7'b0} - 39'({r2_px, 2'b0}) + 39'(r2_px);
        r3_dz  <= {r2_d, 6'b0};
        r3_dy  <= {r2_dfy, 6'b0};
    end

    dxyz_div #(.MAG_W(39), .DEN_W(22)) u_div_z (
        .i_clk (i_clk),
        .i_mag (r3_nz),
        .i_den (r3_dz),
        .o_quo (w_qz),
        .o_ovf (w_oz)
    );

    dxyz_div #(.MAG_W(39), .DEN_W(22)) u_div_x (
        .i_clk (i_clk),
        .i_mag (r3_nx),
        .i_den (r3_dz),
        .o_quo (w_qx),
        .o_ovf (w_ox)
    );

    dxyz_div #(.MAG_W(55), .DEN_W(38)) u_div_y (
        .i_clk (i_clk),
        .i_mag (r3_ny),
        .i_den (r3_dy),
        .o_quo (w_qy),
        .o_ovf (w_oy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_strobe <= r_ml[ML-1].vld;
            r_pv     <= r_ml[ML-1].vld && r_ml[ML-1].pv;
        end
        if (r_ml[ML-1].vld && r_ml[ML-1].pv) begin
            r_x <= sat_signed(w_qx, w_ox, r_ml[ML-1].neg_x);
            r_z <= (w_oz || w_qz[31]) ? 31'h7FFF_FFFF : w_qz[30:0];
            r_y <= r_ml[ML-1].fy_nz ? sat_signed(w_qy, w_oy, r_ml[ML-1].neg_y) : '0;
        end else begin
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_point_valid = r_pv;
    assign o_point_x     = r_x;
    assign o_point_y     = r_y;
    assign o_point_z     = r_z;

    `DXYZ_ASSERT_NOW(a_invalid_zero, o_strobe && !o_point_valid, (o_point_x == '0) && (o_point_y == '0) && (o_point_z == '0), "invalid point carries nonzero coordinates")
    `DXYZ_ASSERT_NOW(a_valid_needs_strobe, !o_strobe, !o_point_valid, "point_valid without strobe")
    `DXYZ_ASSERT_AFTER(a_latency, start && !busy, dxyz_pkg::LATENCY, o_strobe, "result missing after fixed latency")

endmodule

/* rtl/dxyz_cell.sv */
// ----------------------------------------------------------------------------
// dxyz_cell
// One restoring division step: shift in a numerator bit, subtract if it fits.
// ----------------------------------------------------------------------------
module dxyz_cell #(
    parameter int unsigned DW = 24
) (
    input  logic                      i_clk,
    input  logic [DW-1:0]             i_rem,
    input  logic [dxyz_pkg::Q_W-1:0]  i_num,
    input  logic [DW-1:0]             i_den,
    input  logic [dxyz_pkg::Q_W-1:0]  i_quo,
    input  logic                      i_ovf,
    output logic [DW-1:0]             o_rem,
    output logic [dxyz_pkg::Q_W-1:0]  o_num,
    output logic [DW-1:0]             o_den,
    output logic [dxyz_pkg::Q_W-1:0]  o_quo,
    output logic                      o_ovf
);

    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] n_rem;

    logic [DW-1:0]            r_rem;
    logic [dxyz_pkg::Q_W-1:0] r_num;
    logic [DW-1:0]            r_den;
    logic [dxyz_pkg::Q_W-1:0] r_quo;
    logic                     r_ovf;

    always_comb begin
        w_sh   = {i_rem, i_num[dxyz_pkg::Q_W-1]};
        w_diff = w_sh - {1'b0, i_den};
        w_ge   = (w_sh >= {1'b0, i_den});
        n_rem  = w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_num <= {i_num[dxyz_pkg::Q_W-2:0], 1'b0};
        r_den <= i_den;
        r_quo <= {i_quo[dxyz_pkg::Q_W-2:0], w_ge};
        r_ovf <= i_ovf;
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_den = r_den;
    assign o_quo = r_quo;
    assign o_ovf = r_ovf;

endmodule

/* rtl/dxyz_div.sv */
// ----------------------------------------------------------------------------
// dxyz_div
// Pipelined rounding divider: floor((2*mag + den) / (2*den)), 32 quotient
// bits from a chain of division cells, with an overflow flag.
// ----------------------------------------------------------------------------
module dxyz_div #(
    parameter int unsigned MAG_W = 39,
    parameter int unsigned DEN_W = 22
) (
    input  logic                      i_clk,
    input  logic [MAG_W-1:0]          i_mag,
    input  logic [DEN_W-1:0]          i_den,
    output logic [dxyz_pkg::Q_W-1:0]  o_quo,
    output logic                      o_ovf
);

    localparam int unsigned QW  = dxyz_pkg::Q_W;
    localparam int unsigned NPW = ((MAG_W > DEN_W) ? MAG_W : DEN_W) + 2;
    localparam int unsigned DW  = DEN_W + 1;
    localparam int unsigned HW  = NPW - QW;
    localparam int unsigned CW  = (HW > DW) ? HW : DW;

    logic [NPW-1:0] w_np;
    logic [DW-1:0]  w_dp;
    logic [HW-1:0]  w_hi;
    logic           w_ovf;

    logic [DW-1:0] w_rem [QW+1];
    logic [QW-1:0] w_num [QW+1];
    logic [DW-1:0] w_den [QW+1];
    logic [QW-1:0] w_quo [QW+1];
    logic          w_ov  [QW+1];

    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic          r_ovf;

    always_comb begin
        w_np  = NPW'({i_mag, 1'b0}) + NPW'(i_den);
        w_dp  = {i_den, 1'b0};
        w_hi  = w_np[NPW-1:QW];
        w_ovf = (CW'(w_hi) >= CW'(w_dp));
    end

    always_ff @(posedge i_clk) begin
        r_rem <= DW'(w_hi);
        r_num <= w_np[QW-1:0];
        r_den <= w_dp;
        r_ovf <= w_ovf;
    end

    assign w_rem[0] = r_rem;
    assign w_num[0] = r_num;
    assign w_den[0] = r_den;
    assign w_quo[0] = '0;
    assign w_ov[0]  = r_ovf;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        dxyz_cell #(.DW(DW)) u_cell (
            .i_clk (i_clk),
            .i_rem (w_rem[g]),
            .i_num (w_num[g]),
            .i_den (w_den[g]),
            .i_quo (w_quo[g]),
            .i_ovf (w_ov[g]),
            .o_rem (w_rem[g+1]),
            .o_num (w_num[g+1]),
            .o_den (w_den[g+1]),
            .o_quo (w_quo[g+1]),
            .o_ovf (w_ov[g+1])
        );
    end

    assign o_quo = w_quo[QW];
    assign o_ovf = w_ov[QW];

endmodule
